// File: rtl/sprite_quad_batcher_defines.svh
// Assertion macros for the sprite quad batcher
`ifndef SPRITE_QUAD_BATCHER_DEFINES_SVH
`define SPRITE_QUAD_BATCHER_DEFINES_SVH

// same-cycle implication
`define SQB_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SQB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/sqb_pkg.sv
// Shared constants, types and FSM states of the sprite quad batcher
package sqb_pkg;

  localparam int TEXTURE_SLOTS    = 32;
  localparam int VERTEX_CAPACITY  = 262144;
  localparam int INDICES_PER_QUAD = 6;
  localparam int SLOT_W           = 6;
  localparam int IDX_W            = $clog2(TEXTURE_SLOTS);
  localparam int ICOUNT_W         = 19;
  localparam int CUT_INDEX        = (VERTEX_CAPACITY / 4) * INDICES_PER_QUAD;

  localparam logic MODE_END = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic        look;
    logic        clear;
    logic        pre_clear;
    logic [31:0] id;
  } tab_req_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              cut;
  } tab_rsp_t;

endpackage

// File: rtl/sprite_quad_batcher.sv
// Sprite quad batcher top level: sprite items in, four vertices out per sprite, one end marker per end item
// An accepted item passes through ST_LOOK to ST_EMIT; a sprite then gives 4 vertices.
// A new item is accepted only in ST_IDLE, after the last output of the one before;
// in_stall stays high through the lookup state and the single vertex output port.
// Reset: synchronous; clears the FSM, index count and texture count.
`include "sprite_quad_batcher_defines.svh"

module sprite_quad_batcher
  import sqb_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                mode,
  input  logic signed [31:0]  pos_x,
  input  logic signed [31:0]  pos_y,
  input  logic signed [31:0]  pos_z,
  input  logic signed [31:0]  quad_width,
  input  logic signed [31:0]  quad_height,
  input  logic [31:0]         rgba_color,
  input  logic [31:0]         uv_corner0,
  input  logic [31:0]         uv_corner1,
  input  logic [31:0]         uv_corner2,
  input  logic [31:0]         uv_corner3,
  input  logic [31:0]         texture_name,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  vert_x,
  output logic signed [31:0]  vert_y,
  output logic signed [31:0]  vert_z,
  output logic [31:0]         vert_color,
  output logic [15:0]         vert_u,
  output logic [15:0]         vert_v,
  output logic [SLOT_W-1:0]   tex_slot,
  output logic                batch_cut,
  output logic [ICOUNT_W-1:0] batch_index_count,
  output logic                end_marker,
  output logic                last_of_item
);

  state_t state;
  state_t state_next;

  logic [ICOUNT_W-1:0] index_count;
  logic [1:0]          vtx;

  logic                is_end;
  logic signed [31:0]  px;
  logic signed [31:0]  py;
  logic signed [31:0]  pz;
  logic signed [31:0]  qw;
  logic signed [31:0]  qh;
  logic [31:0]         color;
  logic [31:0]         uv0;
  logic [31:0]         uv1;
  logic [31:0]         uv2;
  logic [31:0]         uv3;
  logic [31:0]         tex_id;

  logic signed [31:0]  x1s;
  logic signed [31:0]  y1s;
  logic [SLOT_W-1:0]   slot;
  logic                cut;
  logic [ICOUNT_W-1:0] cut_cnt;

  logic     cap_cut;
  logic     cut_any;
  tab_req_t tab_req;
  tab_rsp_t tab_rsp;
  logic     accept;
  logic     out_take;
  logic [31:0] uv_sel;

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      sat_add = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      sat_add = s[31:0];
    end
  endfunction

  assign accept   = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  assign cap_cut  = !is_end && (index_count >= ICOUNT_W'(CUT_INDEX));
  assign cut_any  = cap_cut || tab_rsp.cut;

  always_comb begin
    tab_req.look      = (state == ST_LOOK) && !is_end;
    tab_req.clear     = (state == ST_LOOK) && is_end;
    tab_req.pre_clear = cap_cut;
    tab_req.id        = tex_id;
  end

  sqb_tex_table u_table (
    .clk (clk),
    .rst (rst),
    .req (tab_req),
    .rsp (tab_rsp)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: state_next = ST_EMIT;
      ST_EMIT: begin
        if (!out_stall && (is_end || vtx == 2'd3)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state)
      ST_IDLE: in_stall = 1'b0;
      ST_LOOK: in_stall = 1'b1;
      ST_EMIT: out_valid = 1'b1;
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      index_count <= '0;
      vtx         <= '0;
    end else begin
      state <= state_next;
      if (state == ST_LOOK) begin
        if (is_end) begin
          index_count <= '0;
        end else begin
          index_count <= (cut_any ? '0 : index_count) + ICOUNT_W'(INDICES_PER_QUAD);
        end
      end
      if (state == ST_IDLE) begin
        vtx <= '0;
      end else if (out_take) begin
        vtx <= vtx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      is_end <= (mode == MODE_END);
      px     <= pos_x;
      py     <= pos_y;
      pz     <= pos_z;
      qw     <= quad_width;
      qh     <= quad_height;
      color  <= rgba_color;
      uv0    <= uv_corner0;
      uv1    <= uv_corner1;
      uv2    <= uv_corner2;
      uv3    <= uv_corner3;
      tex_id <= texture_name;
    end
    if (state == ST_LOOK) begin
      x1s     <= sat_add(px, qw);
      y1s     <= sat_add(py, qh);
      slot    <= tab_rsp.slot;
      cut     <= cut_any;
      cut_cnt <= index_count;
    end
  end

  // vertex selection: bottom-left, top-left, top-right, bottom-right
  always_comb begin
    vert_x = px;
    vert_y = py;
    uv_sel = uv0;
    case (vtx)
      2'd0: begin
        vert_x = px;
        vert_y = py;
        uv_sel = uv0;
      end
      2'd1: begin
        vert_x = px;
        vert_y = y1s;
        uv_sel = uv1;
      end
      2'd2: begin
        vert_x = x1s;
        vert_y = y1s;
        uv_sel = uv2;
      end
      2'd3: begin
        vert_x = x1s;
        vert_y = py;
        uv_sel = uv3;
      end
      default: begin
        vert_x = px;
        vert_y = py;
        uv_sel = uv0;
      end
    endcase
    vert_z            = pz;
    vert_color        = color;
    vert_u            = uv_sel[31:16];
    vert_v            = uv_sel[15:0];
    tex_slot          = slot;
    batch_cut         = cut && (vtx == 2'd0);
    batch_index_count = (cut && (vtx == 2'd0)) ? cut_cnt : '0;
    end_marker        = 1'b0;
    last_of_item      = (vtx == 2'd3);
    if (is_end) begin
      vert_x            = '0;
      vert_y            = '0;
      vert_z            = '0;
      vert_color        = '0;
      vert_u            = '0;
      vert_v            = '0;
      tex_slot          = '0;
      batch_cut         = 1'b0;
      batch_index_count = cut_cnt;
      end_marker        = 1'b1;
      last_of_item      = 1'b1;
    end
  end

  `SQB_ASSERT_IMPL(a_cut_first, out_valid && batch_cut, !end_marker && !last_of_item, "cut off first vertex")
  `SQB_ASSERT_IMPL(a_end_single, out_valid && end_marker, last_of_item && tex_slot == '0, "bad end item")
  `SQB_ASSERT_IMPL(a_slot_range, out_valid, tex_slot <= SLOT_W'(TEXTURE_SLOTS), "slot out of range")
  `SQB_ASSERT_NEXT(a_look_gap, in_valid && !in_stall, !out_valid && in_stall, "no lookup cycle")

endmodule

// File: rtl/sqb_cell.sv
// One texture table entry: holds an id, compares it and passes it on
module sqb_cell
  import sqb_pkg::*;
(
  input  logic        clk,
  input  logic        shift,
  input  logic [31:0] d_in,
  input  logic [31:0] query,
  input  logic        en,
  output logic [31:0] entry,
  output logic        match
);

  always_ff @(posedge clk) begin
    if (shift) begin
      entry <= d_in;
    end
  end

  assign match = en && (entry == query);

endmodule

// File: rtl/sqb_tex_table.sv
// Texture table as a shifting chain of cells with a fill count
module sqb_tex_table
  import sqb_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  tab_req_t req,
  output tab_rsp_t rsp
);

  logic [SLOT_W-1:0]        count;
  logic [SLOT_W-1:0]        count_next;
  logic [SLOT_W-1:0]        eff_count;
  logic [TEXTURE_SLOTS-1:0] match;
  logic [31:0]              entry [TEXTURE_SLOTS];
  logic [IDX_W-1:0]         hit_idx;
  logic                     hit;
  logic                     id_zero;
  logic                     shift;
  logic                     full;

  assign eff_count = req.pre_clear ? '0 : count;
  assign id_zero   = (req.id == 32'd0);
  assign full      = (eff_count == SLOT_W'(TEXTURE_SLOTS));

  // newest entry sits in cell 0; cell j holds slot count - j
  for (genvar j = 0; j < TEXTURE_SLOTS; j++) begin : g_cell
    sqb_cell u_cell (
      .clk   (clk),
      .shift (shift),
      .d_in  ((j == 0) ? req.id : entry[(j == 0) ? 0 : j - 1]),
      .query (req.id),
      .en    (SLOT_W'(j) < eff_count),
      .entry (entry[j]),
      .match (match[j])
    );
  end

  always_comb begin
    hit_idx = '0;
    for (int j = 0; j < TEXTURE_SLOTS; j++) begin
      if (match[j]) begin
        hit_idx = hit_idx | IDX_W'(j);
      end
    end
  end

  assign hit   = |match;
  assign shift = req.look && !id_zero && !hit;

  always_comb begin
    rsp.cut    = 1'b0;
    rsp.slot   = '0;
    count_next = eff_count;
    if (!id_zero) begin
      if (hit) begin
        rsp.slot = eff_count - {1'b0, hit_idx};
      end else if (full) begin
        rsp.cut    = 1'b1;
        count_next = SLOT_W'(1);
        rsp.slot   = SLOT_W'(1);
      end else begin
        count_next = eff_count + SLOT_W'(1);
        rsp.slot   = count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (req.clear) begin
      count <= '0;
    end else if (req.look) begin
      count <= count_next;
    end
  end

endmodule

// File: sim/tb_sprite_quad_batcher.sv
`timescale 1ns / 100ps
// Self-checking testbench for the sprite quad batcher: directed and random items
module tb_sprite_quad_batcher;
  import sqb_pkg::*;

  localparam int TIMEOUT_CYCLES = 3_000_000;
  localparam int TAIL_CYCLES    = 20;
  localparam int PHASE_ITEMS    = 65;
  localparam int ID_POOL        = 40;
  localparam int SEND_IDLE_PCT [4] = '{0, 78, 0, 18};
  localparam int STALL_PCT     [4] = '{0, 0, 78, 18};

  typedef struct packed {
    logic             mode;
    logic [31:0]      pos_x, pos_y, pos_z, quad_width, quad_height, rgba_color;
    logic [3:0][31:0] uv;
    logic [31:0]      texture_name;
  } sprite_t;

  typedef struct packed {
    logic [31:0]         x, y, z, color;
    logic [15:0]         u, v;
    logic [SLOT_W-1:0]   slot;
    logic                cut;
    logic [ICOUNT_W-1:0] count;
    logic                end_mark, last;
  } vertex_t;

  class quad_scoreboard;
    logic [31:0] tex_ids [TEXTURE_SLOTS];
    int unsigned tex_count, idx_count;
    vertex_t     pending_vertices[$];
    int unsigned errors, sprites, ends, checked, table_cuts, capacity_cuts;

    function void clear_batch();
      idx_count = 0;
      tex_count = 0;
    endfunction

    function logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
      longint s;
      s = longint'($signed(a)) + longint'($signed(b));
      if (s > 64'sd2147483647) s = 64'sd2147483647;
      if (s < -64'sd2147483648) s = -64'sd2147483648;
      return s[31:0];
    endfunction

    function void note_sprite(sprite_t s);
      vertex_t           vtx;
      logic [31:0]       xs [4];
      logic [31:0]       ys [4];
      logic [31:0]       x1, y1;
      logic [SLOT_W-1:0] slot;
      bit                cut, hit;
      int unsigned       cut_count;
      int                i;
      vtx = '0;
      if (s.mode == MODE_END) begin
        vtx.count = idx_count[ICOUNT_W-1:0];
        vtx.end_mark = 1'b1;
        vtx.last = 1'b1;
        pending_vertices = {pending_vertices, vtx};
        ends++;
        clear_batch();
        return;
      end
      sprites++;
      cut = 0;
      hit = 0;
      cut_count = 0;
      slot = '0;
      if (idx_count / INDICES_PER_QUAD >= VERTEX_CAPACITY / 4) begin
        cut = 1;
        cut_count = idx_count;
        clear_batch();
        capacity_cuts++;
      end
      if (s.texture_name != 32'd0) begin
        for (i = 0; i < tex_count; i++)
          if (!hit && tex_ids[i] == s.texture_name) begin
            hit = 1;
            slot = SLOT_W'(i + 1);
          end
        if (!hit) begin
          if (tex_count >= TEXTURE_SLOTS) begin
            cut = 1;
            cut_count = idx_count;
            clear_batch();
            table_cuts++;
          end
          tex_ids[tex_count] = s.texture_name;
          tex_count++;
          slot = SLOT_W'(tex_count);
        end
      end
      x1 = sat_sum(s.pos_x, s.quad_width);
      y1 = sat_sum(s.pos_y, s.quad_height);
      // bottom-left, top-left, top-right, bottom-right
      xs = '{s.pos_x, s.pos_x, x1, x1};
      ys = '{s.pos_y, y1, y1, s.pos_y};
      for (i = 0; i < 4; i++) begin
        vtx = '0;
        vtx.x = xs[i];
        vtx.y = ys[i];
        vtx.z = s.pos_z;
        vtx.color = s.rgba_color;
        vtx.u = s.uv[i][31:16];
        vtx.v = s.uv[i][15:0];
        vtx.slot = slot;
        if (i == 0 && cut) begin
          vtx.cut = 1'b1;
          vtx.count = cut_count[ICOUNT_W-1:0];
        end
        vtx.last = (i == 3);
        pending_vertices = {pending_vertices, vtx};
      end
      idx_count += INDICES_PER_QUAD;
    endfunction

    function void cmp(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_vertex(vertex_t got);
      vertex_t want;
      if (pending_vertices.size() == 0) begin
        $error("vertex output with nothing outstanding");
        errors++;
        return;
      end
      want = pending_vertices.pop_front();
      checked++;
      cmp("vert_x", want.x, got.x);
      cmp("vert_y", want.y, got.y);
      cmp("vert_z", want.z, got.z);
      cmp("vert_color", want.color, got.color);
      cmp("vert_u", 32'(want.u), 32'(got.u));
      cmp("vert_v", 32'(want.v), 32'(got.v));
      cmp("tex_slot", 32'(want.slot), 32'(got.slot));
      cmp("batch_cut", 32'(want.cut), 32'(got.cut));
      cmp("batch_index_count", 32'(want.count), 32'(got.count));
      cmp("end_marker", 32'(want.end_mark), 32'(got.end_mark));
      cmp("last_of_item", 32'(want.last), 32'(got.last));
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                mode = 1'b0;
  logic signed [31:0]  pos_x = '0, pos_y = '0, pos_z = '0;
  logic signed [31:0]  quad_width = '0, quad_height = '0;
  logic [31:0]         rgba_color = '0, texture_name = '0;
  logic [31:0]         uv_corner0 = '0, uv_corner1 = '0, uv_corner2 = '0, uv_corner3 = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic signed [31:0]  vert_x, vert_y, vert_z;
  logic [31:0]         vert_color;
  logic [15:0]         vert_u, vert_v;
  logic [SLOT_W-1:0]   tex_slot;
  logic                batch_cut;
  logic [ICOUNT_W-1:0] batch_index_count;
  logic                end_marker, last_of_item;

  vertex_t        seen_vertex;
  quad_scoreboard sb;
  int             send_idle_pct = 0;
  int             stall_pct = 0;
  int             cycle_count = 0;
  logic [31:0]    id_pool [ID_POOL];

  assign seen_vertex = {vert_x, vert_y, vert_z, vert_color, vert_u, vert_v, tex_slot,
                        batch_cut, batch_index_count, end_marker, last_of_item};

  sprite_quad_batcher u_top (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic bit roll(int pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  function automatic logic [31:0] pick_q16();
    case ($urandom_range(7, 0))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return $urandom() >> 8;
      4: return -($urandom() >> 8);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_texture();
    int r;
    r = $urandom_range(99, 0);
    if (r < 15) return 32'h0;
    if (r < 40) return $urandom();
    return id_pool[$urandom_range(ID_POOL - 1, 0)];
  endfunction

  function automatic sprite_t random_sprite();
    sprite_t s;
    s.mode = ($urandom_range(79, 0) == 0) ? MODE_END : ~MODE_END;
    s.pos_x = pick_q16();
    s.pos_y = pick_q16();
    s.pos_z = pick_q16();
    s.quad_width = pick_q16();
    s.quad_height = pick_q16();
    s.rgba_color = $urandom();
    for (int i = 0; i < 4; i++) s.uv[i] = $urandom();
    s.texture_name = pick_texture();
    return s;
  endfunction

  task automatic send_sprite(input sprite_t s);
    if (roll(send_idle_pct)) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (roll(send_idle_pct));
    end
    mode <= s.mode;
    pos_x <= s.pos_x;
    pos_y <= s.pos_y;
    pos_z <= s.pos_z;
    quad_width <= s.quad_width;
    quad_height <= s.quad_height;
    rgba_color <= s.rgba_color;
    uv_corner0 <= s.uv[0];
    uv_corner1 <= s.uv[1];
    uv_corner2 <= s.uv[2];
    uv_corner3 <= s.uv[3];
    texture_name <= s.texture_name;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_sprite(s);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_vertex(seen_vertex);
    out_stall <= roll(stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == TIMEOUT_CYCLES) begin
      $display("sprite_quad_batcher regression: fail");
      $finish;
    end
  end

  initial begin
    sprite_t s;
    sb = new();
    for (int i = 0; i < ID_POOL; i++) id_pool[i] = $urandom() | 32'h1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // end on an empty batch, fields ignored
    s = random_sprite();
    s.mode = MODE_END;
    send_sprite(s);
    // positive saturation on both axes
    s = random_sprite();
    s.mode = ~MODE_END;
    s.pos_x = 32'h7FFF_FFFF; s.quad_width = 32'h7FFF_FFFF;
    s.pos_y = 32'h7FFF_FFFF; s.quad_height = 32'h1;
    s.pos_z = 32'h8000_0000; s.rgba_color = '1;
    s.uv = '1; s.texture_name = 32'h0;
    send_sprite(s);
    // negative saturation, all-ones id
    s.pos_x = 32'h8000_0000; s.quad_width = 32'h8000_0000;
    s.pos_y = 32'h8000_0000; s.quad_height = 32'hFFFF_FFFF;
    s.pos_z = 32'h7FFF_FFFF; s.rgba_color = '0;
    s.uv = '0; s.texture_name = 32'hFFFF_FFFF;
    send_sprite(s);
    // extremes that cancel, distinct corners
    s.pos_x = 32'h7FFF_FFFF; s.quad_width = 32'h8000_0000;
    s.pos_y = 32'h0; s.quad_height = 32'h0; s.pos_z = 32'h0;
    s.uv[0] = 32'h1234_5678; s.uv[1] = 32'h9ABC_DEF0;
    s.uv[2] = 32'h0F0F_F0F0; s.uv[3] = 32'hA5A5_5A5A;
    s.texture_name = 32'h1;
    send_sprite(s);
    // table hits and untextured
    s = random_sprite(); s.mode = ~MODE_END; s.texture_name = 32'hFFFF_FFFF;
    send_sprite(s);
    s = random_sprite(); s.mode = ~MODE_END; s.texture_name = 32'h1;
    send_sprite(s);
    s = random_sprite(); s.mode = ~MODE_END; s.texture_name = 32'h0;
    send_sprite(s);
    s.mode = MODE_END;
    send_sprite(s);
    // table must be empty after the end item
    s = random_sprite(); s.mode = ~MODE_END; s.texture_name = 32'h1;
    send_sprite(s);
    s.mode = MODE_END;
    send_sprite(s);

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = SEND_IDLE_PCT[p];
      stall_pct = STALL_PCT[p];
      repeat (PHASE_ITEMS) send_sprite(random_sprite());
    end

    // close the last batch
    s = random_sprite();
    s.mode = MODE_END;
    send_sprite(s);

    in_valid <= 1'b0;
    while (sb.pending_vertices.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d sprites and %0d end items sent, %0d results checked",
             sb.sprites, sb.ends, sb.checked);
    $display("batches cut on a full texture table: %0d, on a full vertex store: %0d",
             sb.table_cuts, sb.capacity_cuts);
    if (sb.errors == 0) begin
      $display("sprite_quad_batcher regression: pass");
    end else begin
      $display("sprite_quad_batcher regression: fail");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/sqb_pkg.sv
rtl/sqb_cell.sv
rtl/sqb_tex_table.sv
rtl/sprite_quad_batcher.sv
sim/tb_sprite_quad_batcher.sv
